### src/tsc_pkg.sv
// Package for the Taylor sine/cosine block: formats, constants, types and helpers.
package tsc_pkg;

    localparam int RANK_CAP_DEFAULT = 15;
    localparam int RANK_LIMIT       = 20;

    localparam logic [3:0]  TERM_COUNT_RESET = 4'd10;
    localparam logic [30:0] TWO_PI_Q28       = 31'd1686629713;
    localparam logic [63:0] ONE_Q48          = 64'd1 << 48;
    localparam logic [63:0] TWO_P48          = 64'd1 << 48;

    // reciprocal table indexed by k, entry = round(2^48 / (k*(k+1)))
    localparam int RECIP_DEPTH = 2 * RANK_LIMIT + 1;
    localparam int RECIP_IW    = $clog2(RECIP_DEPTH);

    localparam logic [47:0] RECIP_TABLE [RECIP_DEPTH] = '{
        48'd0,
        48'((TWO_P48 + 64'd1)   / 64'd2),
        48'((TWO_P48 + 64'd3)   / 64'd6),
        48'((TWO_P48 + 64'd6)   / 64'd12),
        48'((TWO_P48 + 64'd10)  / 64'd20),
        48'((TWO_P48 + 64'd15)  / 64'd30),
        48'((TWO_P48 + 64'd21)  / 64'd42),
        48'((TWO_P48 + 64'd28)  / 64'd56),
        48'((TWO_P48 + 64'd36)  / 64'd72),
        48'((TWO_P48 + 64'd45)  / 64'd90),
        48'((TWO_P48 + 64'd55)  / 64'd110),
        48'((TWO_P48 + 64'd66)  / 64'd132),
        48'((TWO_P48 + 64'd78)  / 64'd156),
        48'((TWO_P48 + 64'd91)  / 64'd182),
        48'((TWO_P48 + 64'd105) / 64'd210),
        48'((TWO_P48 + 64'd120) / 64'd240),
        48'((TWO_P48 + 64'd136) / 64'd272),
        48'((TWO_P48 + 64'd153) / 64'd306),
        48'((TWO_P48 + 64'd171) / 64'd342),
        48'((TWO_P48 + 64'd190) / 64'd380),
        48'((TWO_P48 + 64'd210) / 64'd420),
        48'((TWO_P48 + 64'd231) / 64'd462),
        48'((TWO_P48 + 64'd253) / 64'd506),
        48'((TWO_P48 + 64'd276) / 64'd552),
        48'((TWO_P48 + 64'd300) / 64'd600),
        48'((TWO_P48 + 64'd325) / 64'd650),
        48'((TWO_P48 + 64'd351) / 64'd702),
        48'((TWO_P48 + 64'd378) / 64'd756),
        48'((TWO_P48 + 64'd406) / 64'd812),
        48'((TWO_P48 + 64'd435) / 64'd870),
        48'((TWO_P48 + 64'd465) / 64'd930),
        48'((TWO_P48 + 64'd496) / 64'd992),
        48'((TWO_P48 + 64'd528) / 64'd1056),
        48'((TWO_P48 + 64'd561) / 64'd1122),
        48'((TWO_P48 + 64'd595) / 64'd1190),
        48'((TWO_P48 + 64'd630) / 64'd1260),
        48'((TWO_P48 + 64'd666) / 64'd1332),
        48'((TWO_P48 + 64'd703) / 64'd1406),
        48'((TWO_P48 + 64'd741) / 64'd1482),
        48'((TWO_P48 + 64'd780) / 64'd1560),
        48'((TWO_P48 + 64'd820) / 64'd1640)
    };

    // post-multiply rounding shift
    typedef enum logic [1:0] {
        SH_24,
        SH_28,
        SH_48
    } t_shift;

    typedef struct packed {
        logic   start;
        t_shift shift;
    } t_mul_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_XSQ,
        ST_CT_XSQ,
        ST_CT_REC,
        ST_ST_XSQ,
        ST_ST_REC,
        ST_FIN
    } t_state;

    // signed Q16.48 to Q8.24, rounded and clamped to 32 bits
    function automatic logic signed [31:0] sat_q24(input logic [63:0] acc);
        logic [63:0]        u;
        logic signed [63:0] q;
        u = acc + (64'd1 << 23);
        q = $signed(u) >>> 24;
        if (q > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (q < -64'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return $signed(q[31:0]);
        end
    endfunction

endpackage

### src/tsc_mul.sv
// Shared 64x64 rounding multiplier built from four 32x32 partial products.
module tsc_mul import tsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_mul_req    i_req,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_result
);

    localparam logic [2:0] PP_LAST  = 3'd3;
    localparam logic [2:0] CNT_DONE = 3'd5;

    logic         r_busy, n_busy;
    logic [2:0]   r_cnt, n_cnt;
    logic [63:0]  r_a, r_b;
    t_shift       r_shift;
    logic [63:0]  r_pp;
    logic [1:0]   r_off;
    logic         r_pp_vld;
    logic [127:0] r_acc;

    logic [31:0]  a_limb, b_limb;
    logic [63:0]  n_pp;
    logic [127:0] pp_sh;
    logic [127:0] rnd_const;
    logic         take;

    assign take = !r_busy && i_req.start;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        if (take) begin
            n_busy = 1'b1;
            n_cnt  = 3'd0;
        end else if (r_busy) begin
            if (r_cnt == CNT_DONE) begin
                n_busy = 1'b0;
            end else begin
                n_cnt = r_cnt + 3'd1;
            end
        end
    end

    always_comb begin
        a_limb = r_cnt[1] ? r_a[63:32] : r_a[31:0];
        b_limb = r_cnt[0] ? r_b[63:32] : r_b[31:0];
        n_pp   = {32'd0, a_limb} * {32'd0, b_limb};
    end

    always_comb begin
        case (r_off)
            2'd0:    pp_sh = {64'd0, r_pp};
            2'd1:    pp_sh = {32'd0, r_pp, 32'd0};
            2'd2:    pp_sh = {r_pp, 64'd0};
            default: pp_sh = 128'd0;
        endcase
    end

    // half an LSB of the final shift, preloaded into the sum
    always_comb begin
        case (i_req.shift)
            SH_24:   rnd_const = 128'd1 << 23;
            SH_28:   rnd_const = 128'd1 << 27;
            SH_48:   rnd_const = 128'd1 << 47;
            default: rnd_const = 128'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cnt    <= 3'd0;
            r_pp_vld <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_cnt    <= n_cnt;
            r_pp_vld <= r_busy && (r_cnt <= PP_LAST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_a     <= i_a;
            r_b     <= i_b;
            r_shift <= i_req.shift;
            r_acc   <= rnd_const;
        end else if (r_busy && r_pp_vld) begin
            r_acc <= r_acc + pp_sh;
        end
        if (r_busy && (r_cnt <= PP_LAST)) begin
            r_pp  <= n_pp;
            r_off <= 2'({1'b0, r_cnt[0]} + {1'b0, r_cnt[1]});
        end
    end

    assign o_done = r_busy && (r_cnt == CNT_DONE);

    always_comb begin
        case (r_shift)
            SH_24:   o_result = r_acc[87:24];
            SH_28:   o_result = r_acc[91:28];
            SH_48:   o_result = r_acc[111:48];
            default: o_result = 64'd0;
        endcase
    end

endmodule

### src/taylor_sine_cosine.sv
// Top level: sequencer and term accumulators for the Taylor sine/cosine block.
//
// Use: one phase word in (i_phase, fraction of a turn), one word out carrying
// o_sine_value and o_cosine_value in signed Q8.24. Both channels are valid/
// stall: a word moves on a rising edge with valid high and stall low.
// i_cfg_we with i_cfg_wdata sets term_count (highest rank summed); write it
// only while the block is idle. Ranks above RANK_CAP are clipped.
// Datapath: all arithmetic runs through one 32x32 multiplier, four partial
// products per 64-bit multiply. An item needs 2 + 4*R multiplies, where
// R = min(term_count, RANK_CAP). Only one phase is worked on at a time;
// o_in_stall is high meanwhile. The result sits in an output register, so
// the next phase is taken while a stalled result waits; if the receiver
// still stalls when the next result is done, the sequencer holds in its
// final state until the register frees.
// Reset (synchronous, active low) returns to idle, drops o_out_valid and sets
// term_count back to ten.
module taylor_sine_cosine import tsc_pkg::*; #(
    parameter int RANK_CAP = RANK_CAP_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [23:0]        i_phase,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_sine_value,
    output logic signed [31:0] o_cosine_value
);

    localparam int RANK_W = $clog2(RANK_CAP + 1);

    t_state              r_state, n_state;
    logic [3:0]          r_term_count;
    logic [RANK_W-1:0]   r_rank, r_ranks, n_ranks;
    logic                r_out_valid;
    logic [23:0]         r_phase;
    logic [30:0]         r_x;      // Q3.28
    logic [34:0]         r_xsq;    // Q7.28
    logic [63:0]         r_ct, r_st;       // term magnitudes, Q16.48
    logic [63:0]         r_cacc, r_sacc;   // signed Q16.48 sums
    logic signed [31:0]  r_sine, r_cosine;

    t_mul_req            mul_req;
    logic [63:0]         mul_a, mul_b, mul_res;
    logic                mul_done;
    logic                in_acc, fin_load;
    logic [RANK_W:0]     k_cos, k_sin;

    tsc_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (mul_req),
        .i_a      (mul_a),
        .i_b      (mul_b),
        .o_done   (mul_done),
        .o_result (mul_res)
    );

    assign in_acc   = i_in_valid && !o_in_stall;
    assign fin_load = (r_state == ST_FIN) && (!r_out_valid || !i_out_stall);

    // reciprocal index: cosine k = 2n-1, sine k = 2n
    assign k_sin = {r_rank, 1'b0};
    assign k_cos = k_sin - {{RANK_W{1'b0}}, 1'b1};

    assign n_ranks = (int'(r_term_count) > RANK_CAP) ? RANK_W'(RANK_CAP)
                                                     : RANK_W'(r_term_count);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) n_state = ST_MUL_X;
            end
            ST_MUL_X: begin
                if (mul_done) n_state = ST_MUL_XSQ;
            end
            ST_MUL_XSQ: begin
                if (mul_done) n_state = (r_ranks == '0) ? ST_FIN : ST_CT_XSQ;
            end
            ST_CT_XSQ: begin
                if (mul_done) n_state = ST_CT_REC;
            end
            ST_CT_REC: begin
                if (mul_done) n_state = ST_ST_XSQ;
            end
            ST_ST_XSQ: begin
                if (mul_done) n_state = ST_ST_REC;
            end
            ST_ST_REC: begin
                if (mul_done) n_state = (r_rank == r_ranks) ? ST_FIN : ST_CT_XSQ;
            end
            ST_FIN: begin
                if (fin_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // multiplier operands and handshake outputs
    always_comb begin
        mul_req.start = 1'b1;
        mul_req.shift = SH_28;
        mul_a         = r_ct;
        mul_b         = 64'(r_xsq);
        o_in_stall    = 1'b1;
        case (r_state)
            ST_IDLE: begin
                mul_req.start = 1'b0;
                o_in_stall    = 1'b0;
            end
            ST_MUL_X: begin
                mul_req.shift = SH_24;
                mul_a         = 64'(r_phase);
                mul_b         = 64'(TWO_PI_Q28);
            end
            ST_MUL_XSQ: begin
                mul_a = 64'(r_x);
                mul_b = 64'(r_x);
            end
            ST_CT_XSQ: begin
                mul_a = r_ct;
            end
            ST_CT_REC: begin
                mul_req.shift = SH_48;
                mul_a         = r_ct;
                mul_b         = 64'(RECIP_TABLE[RECIP_IW'(k_cos)]);
            end
            ST_ST_XSQ: begin
                mul_a = r_st;
            end
            ST_ST_REC: begin
                mul_req.shift = SH_48;
                mul_a         = r_st;
                mul_b         = 64'(RECIP_TABLE[RECIP_IW'(k_sin)]);
            end
            ST_FIN: begin
                mul_req.start = 1'b0;
            end
            default: begin
                mul_req.start = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_term_count <= TERM_COUNT_RESET;
            r_out_valid  <= 1'b0;
            r_rank       <= '0;
            r_ranks      <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_term_count <= i_cfg_wdata;
            if (fin_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc) begin
                r_rank  <= RANK_W'(1);
                r_ranks <= n_ranks;
            end else if ((r_state == ST_ST_REC) && mul_done && (r_rank != r_ranks)) begin
                r_rank <= r_rank + RANK_W'(1);
            end
        end
    end

    // datapath: odd ranks subtract, even ranks add
    always_ff @(posedge i_clk) begin
        if (in_acc) r_phase <= i_phase;
        if (mul_done) begin
            case (r_state)
                ST_MUL_X: r_x <= mul_res[30:0];
                ST_MUL_XSQ: begin
                    r_xsq  <= mul_res[34:0];
                    r_ct   <= ONE_Q48;
                    r_cacc <= ONE_Q48;
                    r_st   <= {13'd0, r_x, 20'd0};
                    r_sacc <= {13'd0, r_x, 20'd0};
                end
                ST_CT_XSQ: r_ct <= mul_res;
                ST_CT_REC: begin
                    r_ct   <= mul_res;
                    r_cacc <= r_rank[0] ? (r_cacc - mul_res) : (r_cacc + mul_res);
                end
                ST_ST_XSQ: r_st <= mul_res;
                ST_ST_REC: begin
                    r_st   <= mul_res;
                    r_sacc <= r_rank[0] ? (r_sacc - mul_res) : (r_sacc + mul_res);
                end
                default: ;
            endcase
        end
        if (fin_load) begin
            r_sine   <= sat_q24(r_sacc);
            r_cosine <= sat_q24(r_cacc);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sine_value   = r_sine;
    assign o_cosine_value = r_cosine;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_MUL_X))
        else $error("accepted phase did not start the x multiply");

    a_done_in_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> ((r_state == ST_MUL_X) || (r_state == ST_MUL_XSQ) ||
                      (r_state == ST_CT_XSQ) || (r_state == ST_CT_REC) ||
                      (r_state == ST_ST_XSQ) || (r_state == ST_ST_REC)))
        else $error("multiplier finished outside a multiply state");

    a_rank_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_CT_XSQ) || (r_state == ST_CT_REC) ||
         (r_state == ST_ST_XSQ) || (r_state == ST_ST_REC))
        |-> ((r_rank != '0) && (r_rank <= r_ranks)))
        else $error("rank counter out of range");

    a_fin_presents: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_load |=> (o_out_valid && (r_state == ST_IDLE)))
        else $error("finished result not presented");
`endif

endmodule
